// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BMM_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define BMM_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bmm_pkg.sv =====
// Types and constants of the banked memory mapper.
`default_nettype none
package bmm_pkg;

    localparam int DESC_COUNT = 4;
    localparam int DESC_W     = 44;
    localparam int REG_W      = 2;
    localparam int BANK_W     = 3;
    localparam int CNT_W      = 4;
    localparam int ADDR_W     = 16;

    typedef enum logic [2:0] {
        OP_READ    = 3'd0,
        OP_WRITE   = 3'd1,
        OP_READ16  = 3'd2,
        OP_WRITE16 = 3'd3,
        OP_SWITCH  = 3'd4,
        OP_LOAD    = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNMAPPED  = 2'd1,
        ST_NO_REGION = 2'd2,
        ST_BANK_OOR  = 2'd3
    } status_t;

    // Region descriptor as written through the configuration port.
    typedef struct packed {
        logic [7:0]        mask;
        logic [CNT_W-1:0]  count;
        logic [ADDR_W-1:0] high;
        logic [ADDR_W-1:0] low;
    } desc_t;

    // Result of mapping one address.
    typedef struct packed {
        logic              hit;
        logic [REG_W-1:0]  region;
        logic [BANK_W-1:0] bank;
        logic [ADDR_W-1:0] off;
        logic              writable;
    } map_t;

    // Result of matching a bank switch range.
    typedef struct packed {
        logic             hit;
        logic [REG_W-1:0] region;
    } sw_t;

endpackage
`default_nettype wire

// ===== rtl/bmm_store.sv =====
// Byte-wide single-port bank store with registered read data.
`default_nettype none
module bmm_store #(
    parameter int DEPTH = 262144,
    parameter int AW    = 18
) (
    input  logic          clk,
    input  logic          en,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== rtl/bmm_regions.sv =====
// Region descriptors, current bank pointers, address mapping and switch matching.
`default_nettype none
module bmm_regions #(
    parameter int NUM_REGIONS  = 4,
    parameter int NUM_BANKS    = 4,
    parameter int REGION_BYTES = 16384
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [bmm_pkg::REG_W-1:0]     cfg_index,
    input  bmm_pkg::desc_t                cfg_desc,
    input  logic [bmm_pkg::ADDR_W-1:0]    lookup_addr,
    output bmm_pkg::map_t                 map,
    input  logic                          sw_apply,
    input  logic [bmm_pkg::ADDR_W-1:0]    sw_low,
    input  logic [bmm_pkg::ADDR_W-1:0]    sw_high,
    output bmm_pkg::sw_t                  sw,
    input  logic [bmm_pkg::REG_W-1:0]     load_region,
    output logic [bmm_pkg::CNT_W-1:0]     load_count
);
    import bmm_pkg::*;

    localparam int NREG = (NUM_REGIONS < DESC_COUNT) ? NUM_REGIONS : DESC_COUNT;
    localparam int RIW  = (NREG > 1) ? $clog2(NREG) : 1;

    desc_t             desc_reg [NREG];
    logic [BANK_W-1:0] bank_reg [NREG];

    logic [CNT_W-1:0]  cnt_eff [NREG];
    logic [ADDR_W-1:0] diff [NREG];
    logic [BANK_W:0]   bank_inc;
    logic [BANK_W-1:0] bank_next;
    logic              cfg_hit;

    // Counts above the bank capacity act as the capacity.
    always_comb
    begin
        for (int r = 0; r < NREG; r++)
        begin
            cnt_eff[r] = (desc_reg[r].count > CNT_W'(NUM_BANKS)) ?
                         CNT_W'(NUM_BANKS) : desc_reg[r].count;
            diff[r]    = lookup_addr - desc_reg[r].low;
        end
    end

    // Scan downward so the lowest matching region wins.
    always_comb
    begin
        map = '0;
        for (int r = NREG - 1; r >= 0; r--)
        begin
            if (cnt_eff[r] != '0 && lookup_addr >= desc_reg[r].low &&
                lookup_addr <= desc_reg[r].high &&
                {1'b0, diff[r]} < (ADDR_W + 1)'(REGION_BYTES))
            begin
                map.hit      = 1'b1;
                map.region   = REG_W'(r);
                map.bank     = bank_reg[r];
                map.off      = diff[r];
                map.writable = desc_reg[r].mask[bank_reg[r]];
            end
        end
    end

    always_comb
    begin
        sw = '0;
        for (int r = NREG - 1; r >= 0; r--)
        begin
            if (cnt_eff[r] != '0 && desc_reg[r].low == sw_low &&
                desc_reg[r].high == sw_high)
            begin
                sw.hit    = 1'b1;
                sw.region = REG_W'(r);
            end
        end
    end

    // Step the pointer and wrap at the bank count.
    always_comb
    begin
        bank_inc  = {1'b0, bank_reg[sw.region[RIW-1:0]]} + 1'b1;
        bank_next = (bank_inc >= cnt_eff[sw.region[RIW-1:0]]) ? '0 : bank_inc[BANK_W-1:0];
    end

    assign cfg_hit    = cfg_write && ({1'b0, cfg_index} < (REG_W + 1)'(NREG));
    assign load_count = ({1'b0, load_region} < (REG_W + 1)'(NREG)) ?
                        cnt_eff[load_region[RIW-1:0]] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NREG; r++)
            begin
                desc_reg[r] <= '0;
                bank_reg[r] <= '0;
            end
        end
        else if (cfg_hit)
        begin
            desc_reg[cfg_index[RIW-1:0]] <= cfg_desc;
            bank_reg[cfg_index[RIW-1:0]] <= '0;
        end
        else if (sw_apply && sw.hit)
        begin
            bank_reg[sw.region[RIW-1:0]] <= bank_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/banked_memory_mapper_top.sv =====
// Top level of the banked memory mapper: request sequencer around the bank store.
`default_nettype none
// A request is taken when start is high and busy is low. After reset the block
// first clears the bank store, one byte a cycle, across all
// min(NUM_REGIONS,4) * NUM_BANKS * REGION_BYTES bytes (262144 at the defaults);
// busy stays high through that pass, and descriptor writes are taken as ever.
// The store is one byte-wide port, so each byte access has its own state: byte
// write, switch, load and undefined opcodes use S_BYTE0, read adds S_RESP,
// write16 adds S_BYTE1, read16 adds S_BYTE1 and S_RESP. The result appears on
// read_data, written_count and status for exactly one cycle with done high; the
// receiver cannot stall it. Descriptor writes belong in idle time only.
module banked_memory_mapper_top #(
    parameter int NUM_REGIONS  = 4,
    parameter int NUM_BANKS    = 4,
    parameter int REGION_BYTES = 16384
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [bmm_pkg::REG_W-1:0]     cfg_index,
    input  logic [bmm_pkg::DESC_W-1:0]    cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    opcode,
    input  logic [15:0]                   address,
    input  logic [15:0]                   data,
    input  logic [15:0]                   range_high,
    input  logic [1:0]                    region_index,
    input  logic [2:0]                    bank_index,
    output logic                          done,
    output logic [15:0]                   read_data,
    output logic [1:0]                    written_count,
    output logic [1:0]                    status
);
    import bmm_pkg::*;

    localparam int NREG       = (NUM_REGIONS < DESC_COUNT) ? NUM_REGIONS : DESC_COUNT;
    localparam int STORE_SIZE = NREG * NUM_BANKS * REGION_BYTES;
    localparam int AW         = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_BYTE0,
        S_BYTE1,
        S_RESP
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_reg, clr_next;
    op_t               op_reg, op_next;
    logic [15:0]       addr_reg, addr_next;
    logic [15:0]       data_reg, data_next;
    logic [15:0]       rhigh_reg, rhigh_next;
    logic [1:0]        ridx_reg, ridx_next;
    logic [2:0]        bidx_reg, bidx_next;
    logic              ok0_reg, ok0_next;
    logic              hi_hit_reg, hi_hit_next;
    logic [7:0]        lo_reg, lo_next;
    logic              done_reg, done_next;
    logic [15:0]       rd_reg, rd_next;
    logic [1:0]        wc_reg, wc_next;
    logic [1:0]        st_reg, st_next;

    map_t              map;
    sw_t               sw;
    logic [CNT_W-1:0]  load_count;
    logic [15:0]       lookup_addr;
    logic              sw_apply;
    logic              load_ok;
    status_t           load_st;

    logic              mem_en, mem_we;
    logic [AW-1:0]     mem_addr;
    logic [7:0]        mem_wdata, mem_rdata;
    logic [REG_W-1:0]  idx_region;
    logic [BANK_W-1:0] idx_bank;
    logic [15:0]       idx_off;
    logic [31:0]       lin_addr;
    logic              wr_ok;

    assign lookup_addr = (state_reg == S_BYTE1) ? addr_reg + 16'd1 : addr_reg;
    assign sw_apply    = (state_reg == S_BYTE0) && (op_reg == OP_SWITCH);
    assign wr_ok       = map.hit && map.writable;

    bmm_regions #(
        .NUM_REGIONS  (NUM_REGIONS),
        .NUM_BANKS    (NUM_BANKS),
        .REGION_BYTES (REGION_BYTES)
    ) u_regions (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_desc    (cfg_data),
        .lookup_addr (lookup_addr),
        .map         (map),
        .sw_apply    (sw_apply),
        .sw_low      (addr_reg),
        .sw_high     (rhigh_reg),
        .sw          (sw),
        .load_region (ridx_reg),
        .load_count  (load_count)
    );

    // Load status: region first, then bank and offset range.
    always_comb
    begin
        if ({2'b00, ridx_reg} >= 4'(NUM_REGIONS))
        begin
            load_st = ST_NO_REGION;
        end
        else if ({1'b0, bidx_reg} >= load_count ||
                 {1'b0, addr_reg} >= 17'(REGION_BYTES))
        begin
            load_st = ST_BANK_OOR;
        end
        else
        begin
            load_st = ST_OK;
        end
        load_ok = (load_st == ST_OK);
    end

    // Linear store address: region, then bank, then byte offset.
    always_comb
    begin
        if (op_reg == OP_LOAD)
        begin
            idx_region = ridx_reg;
            idx_bank   = bidx_reg;
            idx_off    = addr_reg;
        end
        else
        begin
            idx_region = map.region;
            idx_bank   = map.bank;
            idx_off    = map.off;
        end
        lin_addr = (32'(idx_region) * 32'(NUM_BANKS) + 32'(idx_bank)) * 32'(REGION_BYTES)
                   + 32'(idx_off);
    end

    always_comb
    begin
        mem_en    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = lin_addr[AW-1:0];
        mem_wdata = data_reg[7:0];
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = '0;
            end
            S_BYTE0:
            begin
                case (op_reg)
                    OP_READ, OP_READ16:
                    begin
                        mem_en = map.hit;
                    end
                    OP_WRITE, OP_WRITE16:
                    begin
                        mem_en = wr_ok;
                        mem_we = 1'b1;
                    end
                    OP_LOAD:
                    begin
                        mem_en = load_ok;
                        mem_we = 1'b1;
                    end
                    default:
                    begin
                        mem_en = 1'b0;
                    end
                endcase
            end
            S_BYTE1:
            begin
                mem_wdata = data_reg[15:8];
                if (op_reg == OP_WRITE16)
                begin
                    mem_en = wr_ok;
                    mem_we = 1'b1;
                end
                else
                begin
                    mem_en = map.hit;
                end
            end
            default:
            begin
                mem_en = 1'b0;
            end
        endcase
    end

    bmm_store #(
        .DEPTH (STORE_SIZE),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        op_next     = op_reg;
        addr_next   = addr_reg;
        data_next   = data_reg;
        rhigh_next  = rhigh_reg;
        ridx_next   = ridx_reg;
        bidx_next   = bidx_reg;
        ok0_next    = ok0_reg;
        hi_hit_next = hi_hit_reg;
        lo_next     = lo_reg;
        done_next   = 1'b0;
        rd_next     = rd_reg;
        wc_next     = wc_reg;
        st_next     = st_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(STORE_SIZE - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = op_t'(opcode);
                    addr_next  = address;
                    data_next  = data;
                    rhigh_next = range_high;
                    ridx_next  = region_index;
                    bidx_next  = bank_index;
                    state_next = S_BYTE0;
                end
            end
            S_BYTE0:
            begin
                rd_next    = '0;
                wc_next    = '0;
                st_next    = ST_OK;
                state_next = S_IDLE;
                case (op_reg)
                    OP_READ:
                    begin
                        ok0_next   = map.hit;
                        state_next = S_RESP;
                    end
                    OP_READ16:
                    begin
                        ok0_next   = map.hit;
                        state_next = S_BYTE1;
                    end
                    OP_WRITE:
                    begin
                        done_next = 1'b1;
                        wc_next   = {1'b0, wr_ok};
                        st_next   = wr_ok ? ST_OK : ST_UNMAPPED;
                    end
                    OP_WRITE16:
                    begin
                        ok0_next   = wr_ok;
                        state_next = S_BYTE1;
                    end
                    OP_SWITCH:
                    begin
                        done_next = 1'b1;
                        st_next   = sw.hit ? ST_OK : ST_NO_REGION;
                    end
                    OP_LOAD:
                    begin
                        done_next = 1'b1;
                        st_next   = load_st;
                    end
                    default:
                    begin
                        done_next = 1'b1;
                    end
                endcase
            end
            S_BYTE1:
            begin
                if (op_reg == OP_WRITE16)
                begin
                    done_next  = 1'b1;
                    wc_next    = 2'({1'b0, ok0_reg} + {1'b0, wr_ok});
                    st_next    = (ok0_reg && wr_ok) ? ST_OK : ST_UNMAPPED;
                    state_next = S_IDLE;
                end
                else
                begin
                    // Low byte arrives now; high byte read goes out.
                    lo_next     = ok0_reg ? mem_rdata : 8'd0;
                    hi_hit_next = map.hit;
                    state_next  = S_RESP;
                end
            end
            S_RESP:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (op_reg == OP_READ16)
                begin
                    rd_next = {hi_hit_reg ? mem_rdata : 8'd0, lo_reg};
                    st_next = (ok0_reg && hi_hit_reg) ? ST_OK : ST_UNMAPPED;
                end
                else
                begin
                    rd_next = {8'd0, ok0_reg ? mem_rdata : 8'd0};
                    st_next = ok0_reg ? ST_OK : ST_UNMAPPED;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        addr_reg   <= addr_next;
        data_reg   <= data_next;
        rhigh_reg  <= rhigh_next;
        ridx_reg   <= ridx_next;
        bidx_reg   <= bidx_next;
        ok0_reg    <= ok0_next;
        hi_hit_reg <= hi_hit_next;
        lo_reg     <= lo_next;
        rd_reg     <= rd_next;
        wc_reg     <= wc_next;
        st_reg     <= st_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign read_data     = rd_reg;
    assign written_count = wc_reg;
    assign status        = st_reg;

endmodule
`default_nettype wire

// ===== rtl/bmm_checker.sv =====
// Port-level checker for the banked memory mapper, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module bmm_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        done,
    input  logic [15:0] read_data,
    input  logic [1:0]  written_count,
    input  logic [1:0]  status
);
    import bmm_pkg::*;

    logic accept;

    assign accept = start && !busy;

    `BMM_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy && !done, "request not held busy")
    `BMM_ASSERT(a_done_idle, clk, rst_n, !done || !busy, "result while still busy")
    `BMM_ASSERT(a_count_range, clk, rst_n, !done || written_count != 2'd3, "bad written count")
    `BMM_ASSERT(a_full_write_ok, clk, rst_n, !(done && written_count == 2'd2) || status == ST_OK, "full write not ok")
    `BMM_ASSERT(a_fault_quiet, clk, rst_n, !(done && (status == ST_NO_REGION || status == ST_BANK_OOR)) || (read_data == 16'd0 && written_count == 2'd0), "fault with data")

endmodule

bind banked_memory_mapper_top bmm_checker u_bmm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .read_data     (read_data),
    .written_count (written_count),
    .status        (status)
);
`default_nettype wire

// ===== test/tb_banked_memory_mapper_top.sv =====
// Self-checking testbench for the banked memory mapper: directed and random requests checked against a predictor.
`timescale 1ns / 100ps

module tb_banked_memory_mapper_top;
    import bmm_pkg::*;

    localparam int NUM_REGIONS  = 4;
    localparam int NUM_BANKS    = 4;
    localparam int REGION_BYTES = 16384;
    // The clearing pass after reset alone runs without an accept while it clears every store byte.
    localparam int STALL_LIMIT  = 800000;
    localparam int SETTLE_CYCLES = 8;

    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] address;
        logic [15:0] data;
        logic [15:0] range_high;
        logic [1:0]  region_index;
        logic [2:0]  bank_index;
    } access_t;

    typedef struct {
        access_t     req;
        logic [15:0] rd;
        logic [1:0]  wc;
        status_t     st;
    } reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_write = 1'b0;
    logic [REG_W-1:0]      cfg_index = '0;
    logic [DESC_W-1:0]     cfg_data = '0;

    logic        start = 1'b0;
    logic [2:0]  opcode = '0;
    logic [15:0] address = '0;
    logic [15:0] data = '0;
    logic [15:0] range_high = '0;
    logic [1:0]  region_index = '0;
    logic [2:0]  bank_index = '0;

    logic        busy;
    logic        done;
    logic [15:0] read_data;
    logic [1:0]  written_count;
    logic [1:0]  status;

    // Predictor state
    desc_t      region_cfg [NUM_REGIONS];
    logic [2:0] bank_ptr [NUM_REGIONS];
    logic [7:0] byte_mem [int];

    access_t access_queue [$];
    reply_t  reply_queue [$];

    int mismatches = 0;
    int replies_checked = 0;
    int settings_used = 0;
    int stall_cycles = 0;
    int op_seen [8];
    int status_seen [4];
    int gap_left = 0;
    int burst_left = 0;

    banked_memory_mapper_top #(
        .NUM_REGIONS  (NUM_REGIONS),
        .NUM_BANKS    (NUM_BANKS),
        .REGION_BYTES (REGION_BYTES)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .address       (address),
        .data          (data),
        .range_high    (range_high),
        .region_index  (region_index),
        .bank_index    (bank_index),
        .done          (done),
        .read_data     (read_data),
        .written_count (written_count),
        .status        (status)
    );

    always #2 clk = ~clk;

    initial begin
        for (int r = 0; r < NUM_REGIONS; r++)
        begin
            region_cfg[r] = '0;
            bank_ptr[r] = '0;
        end
        for (int i = 0; i < 8; i++)
        begin
            op_seen[i] = 0;
        end
        for (int i = 0; i < 4; i++)
        begin
            status_seen[i] = 0;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic int unsigned live_banks(input int r);
        return (region_cfg[r].count > NUM_BANKS) ? NUM_BANKS : region_cfg[r].count;
    endfunction

    function automatic int mem_index(input int r, input int unsigned bank, input int unsigned off);
        return (r * NUM_BANKS + bank) * REGION_BYTES + off;
    endfunction

    // Lowest region that maps the address, or -1.
    function automatic int map_address(input logic [15:0] a, output int unsigned off);
        int unsigned delta;
        off = 0;
        for (int r = 0; r < NUM_REGIONS; r++)
        begin
            if (live_banks(r) == 0 || a < region_cfg[r].low || a > region_cfg[r].high)
                continue;
            delta = a - region_cfg[r].low;
            if (delta >= REGION_BYTES)
                continue;
            off = delta;
            return r;
        end
        return -1;
    endfunction

    function automatic bit fetch_byte(input logic [15:0] a, output logic [7:0] v);
        int r;
        int unsigned off;
        int idx;
        v = 8'h00;
        r = map_address(a, off);
        if (r < 0)
            return 1'b0;
        idx = mem_index(r, bank_ptr[r], off);
        if (byte_mem.exists(idx))
            v = byte_mem[idx];
        return 1'b1;
    endfunction

    function automatic bit store_byte(input logic [15:0] a, input logic [7:0] v);
        int r;
        int unsigned off;
        r = map_address(a, off);
        if (r < 0)
            return 1'b0;
        if (!region_cfg[r].mask[bank_ptr[r]])
            return 1'b0;
        byte_mem[mem_index(r, bank_ptr[r], off)] = v;
        return 1'b1;
    endfunction

    function automatic reply_t mapper_outcome(input access_t q);
        reply_t res;
        logic [7:0] lo_b;
        logic [7:0] hi_b;
        bit ok_lo;
        bit ok_hi;
        int hit;
        int unsigned nxt;
        res.req = q;
        res.rd = '0;
        res.wc = '0;
        res.st = ST_OK;
        hit = -1;
        case (q.opcode)
            OP_READ:
            begin
                ok_lo = fetch_byte(q.address, lo_b);
                res.rd = {8'h00, lo_b};
                if (!ok_lo)
                    res.st = ST_UNMAPPED;
            end
            OP_WRITE:
            begin
                ok_lo = store_byte(q.address, q.data[7:0]);
                res.wc = 2'(ok_lo);
                res.st = ok_lo ? ST_OK : ST_UNMAPPED;
            end
            OP_READ16:
            begin
                ok_lo = fetch_byte(q.address, lo_b);
                ok_hi = fetch_byte(q.address + 16'd1, hi_b);
                res.rd = {hi_b, lo_b};
                res.st = (ok_lo && ok_hi) ? ST_OK : ST_UNMAPPED;
            end
            OP_WRITE16:
            begin
                ok_lo = store_byte(q.address, q.data[7:0]);
                ok_hi = store_byte(q.address + 16'd1, q.data[15:8]);
                res.wc = 2'(ok_lo) + 2'(ok_hi);
                res.st = (ok_lo && ok_hi) ? ST_OK : ST_UNMAPPED;
            end
            OP_SWITCH:
            begin
                for (int r = 0; r < NUM_REGIONS; r++)
                begin
                    if (hit < 0 && live_banks(r) != 0 && region_cfg[r].low == q.address
                            && region_cfg[r].high == q.range_high)
                        hit = r;
                end
                if (hit < 0)
                    res.st = ST_NO_REGION;
                else
                begin
                    nxt = bank_ptr[hit] + 1;
                    if (nxt >= live_banks(hit))
                        nxt = 0;
                    bank_ptr[hit] = 3'(nxt);
                end
            end
            OP_LOAD:
            begin
                if (q.region_index >= NUM_REGIONS)
                    res.st = ST_NO_REGION;
                else if (q.bank_index >= live_banks(q.region_index) || q.address >= REGION_BYTES)
                    res.st = ST_BANK_OOR;
                else
                    byte_mem[mem_index(q.region_index, q.bank_index, q.address)] = q.data[7:0];
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic desc_t make_desc(input logic [15:0] lo, input logic [15:0] hi,
                                        input logic [3:0] cnt, input logic [7:0] msk);
        desc_t d;
        d.low = lo;
        d.high = hi;
        d.count = cnt;
        d.mask = msk;
        return d;
    endfunction

    function automatic desc_t random_desc();
        desc_t d;
        logic [15:0] span;
        case ($urandom_range(0, 3))
            0: span = 16'($urandom_range(0, 15));
            1: span = 16'($urandom_range(16, 1023));
            2: span = 16'($urandom_range(16000, 17000));
            default: span = 16'($urandom);
        endcase
        d.low = 16'($urandom);
        // wraps now and then, which gives an inverted range
        d.high = d.low + span;
        d.count = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(1, NUM_BANKS));
        d.mask = 8'($urandom);
        return d;
    endfunction

    function automatic logic [15:0] near_region(input int r);
        desc_t d;
        logic [15:0] span;
        d = region_cfg[r];
        span = d.high - d.low;
        case ($urandom_range(0, 3))
            0: return d.low + 16'($urandom_range(0, 15));
            1: return d.high + 16'd1 - 16'($urandom_range(0, 4));
            2: return d.low - 16'($urandom_range(0, 1));
            default: return d.low + 16'($urandom_range(0, span));
        endcase
    endfunction

    function automatic access_t random_access();
        access_t q;
        int pick;
        int r;
        q.address = 16'($urandom);
        q.data = 16'($urandom);
        q.range_high = 16'($urandom);
        q.region_index = 2'($urandom);
        q.bank_index = 3'($urandom);
        r = $urandom_range(0, NUM_REGIONS - 1);
        pick = $urandom_range(0, 99);
        if (pick < 20)
            q.opcode = OP_READ;
        else if (pick < 40)
            q.opcode = OP_WRITE;
        else if (pick < 55)
            q.opcode = OP_READ16;
        else if (pick < 70)
            q.opcode = OP_WRITE16;
        else if (pick < 80)
            q.opcode = OP_SWITCH;
        else if (pick < 95)
            q.opcode = OP_LOAD;
        else
            q.opcode = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;

        case (q.opcode)
            OP_SWITCH:
            begin
                if ($urandom_range(0, 4) != 0)
                begin
                    q.address = region_cfg[r].low;
                    q.range_high = region_cfg[r].high;
                end
            end
            OP_LOAD:
            begin
                q.region_index = 2'(r);
                if ($urandom_range(0, 3) != 0)
                    q.bank_index = 3'($urandom_range(0, NUM_BANKS - 1));
                case ($urandom_range(0, 3))
                    0, 1: q.address = 16'($urandom_range(0, 15));
                    2: q.address = 16'(REGION_BYTES - 2 + $urandom_range(0, 2));
                    default: ;
                endcase
            end
            OP_READ, OP_WRITE, OP_READ16, OP_WRITE16:
            begin
                if ($urandom_range(0, 4) != 0)
                    q.address = near_region(r);
            end
            default: ;
        endcase
        return q;
    endfunction

    task automatic queue_access(input logic [2:0] op, input logic [15:0] addr,
                                input logic [15:0] wdata, input logic [15:0] rhigh,
                                input logic [1:0] ridx, input logic [2:0] bidx);
        access_t q;
        q.opcode = op;
        q.address = addr;
        q.data = wdata;
        q.range_high = rhigh;
        q.region_index = ridx;
        q.bank_index = bidx;
        access_queue.push_back(q);
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            access_queue.push_back(random_access());
        end
    endtask

    // Descriptor write; also resets the region's bank pointer.
    task automatic write_region(input int r, input desc_t d);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_W'(r);
        cfg_data <= d;
        region_cfg[r] = d;
        bank_ptr[r] = '0;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic load_settings(input desc_t plan [NUM_REGIONS]);
        for (int r = 0; r < DESC_COUNT; r++)
        begin
            write_region(r, plan[r]);
        end
        settings_used++;
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (access_queue.size() != 0 || start || reply_queue.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic flag_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatches++;
    endtask

    // ---------------------------------------------------------------- driver

    always @(posedge clk)
    begin : driver
        logic    fire;
        logic    next_start;
        access_t nxt;
        fire = start && !busy;
        next_start = start && !fire;
        if (rst_n && !next_start)
        begin
            if (gap_left > 0)
                gap_left--;
            else if (access_queue.size() > 0)
            begin
                nxt = access_queue.pop_front();
                opcode <= nxt.opcode;
                address <= nxt.address;
                data <= nxt.data;
                range_high <= nxt.range_high;
                region_index <= nxt.region_index;
                bank_index <= nxt.bank_index;
                next_start = 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: gap_left = 0;
                        4, 5, 6, 7, 8: gap_left = $urandom_range(1, 4);
                        default: gap_left = $urandom_range(5, 20);
                    endcase
                end
            end
        end
        start <= next_start;
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge clk)
    begin : monitor
        access_t q;
        reply_t  want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                q.opcode = opcode;
                q.address = address;
                q.data = data;
                q.range_high = range_high;
                q.region_index = region_index;
                q.bank_index = bank_index;
                want = mapper_outcome(q);
                reply_queue.push_back(want);
                op_seen[opcode]++;
                status_seen[want.st]++;
            end
            if (done)
            begin
                replies_checked++;
                if (reply_queue.size() == 0)
                    flag_mismatch("result with no request outstanding");
                else
                begin
                    want = reply_queue.pop_front();
                    if (read_data !== want.rd)
                        flag_mismatch($sformatf("read_data %h, want %h (op %0d addr %h)",
                                      read_data, want.rd, want.req.opcode, want.req.address));
                    if (written_count !== want.wc)
                        flag_mismatch($sformatf("written_count %0d, want %0d (op %0d addr %h)",
                                      written_count, want.wc, want.req.opcode, want.req.address));
                    if (status !== want.st)
                        flag_mismatch($sformatf("status %0d, want %0d (op %0d addr %h)",
                                      status, want.st, want.req.opcode, want.req.address));
                end
            end
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no progress for %0d cycles", stall_cycles);
            $display("Test completed with failures");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin : stimulus
        desc_t plan [NUM_REGIONS];
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Split map: protected banks in region 0, a top region that wraps to 0,
        // and an unmapped region above region 0.
        plan[0] = make_desc(16'h0000, 16'h3FFF, 4'd4, 8'b0000_0101);
        plan[1] = make_desc(16'h8000, 16'h80FF, 4'd2, 8'hFF);
        plan[2] = make_desc(16'hFF00, 16'hFFFF, 4'd1, 8'h01);
        plan[3] = make_desc(16'h4000, 16'h7FFF, 4'd0, 8'hFF);
        load_settings(plan);

        queue_access(OP_READ,    16'h0000, 16'h0000, 16'h0000, 2'd0, 3'd0);
        queue_access(OP_WRITE,   16'h0000, 16'hFFA5, 16'h0000, 2'd0, 3'd0);
        queue_access(OP_READ,    16'h0000, 16'h0000, 16'h0000, 2'd0, 3'd0);
        queue_access(OP_SWITCH,  16'h0000, 16'h0000, 16'h3FFF, 2'd0, 3'd0);
        queue_access(OP_WRITE,   16'h0001, 16'h0077, 16'h0000, 2'd0, 3'd0);
        queue_access(OP_LOAD,    16'h0000, 16'h005A, 16'h0000, 2'd0, 3'd1);
        queue_access(OP_READ,    16'h0000, 16'h0000, 16'h0000, 2'd0, 3'd0);
        queue_access(OP_LOAD,    16'h0000, 16'h0011, 16'h0000, 2'd0, 3'd7);
        queue_access(OP_LOAD,    16'hFFFF, 16'hFFFF, 16'h0000, 2'd0, 3'd0);
        queue_access(OP_LOAD,    16'h0000, 16'h0022, 16'h0000, 2'd3, 3'd0);
        queue_access(OP_SWITCH,  16'h0000, 16'h0000, 16'h3FFE, 2'd0, 3'd0);
        queue_access(OP_SWITCH,  16'h0000, 16'h0000, 16'h3FFF, 2'd0, 3'd0);
        queue_access(OP_SWITCH,  16'h0000, 16'h0000, 16'h3FFF, 2'd0, 3'd0);
        queue_access(OP_SWITCH,  16'h0000, 16'h0000, 16'h3FFF, 2'd0, 3'd0);
        queue_access(OP_WRITE16, 16'h3FFF, 16'h55AA, 16'h0000, 2'd0, 3'd0);
        queue_access(OP_READ16,  16'h3FFF, 16'h0000, 16'h0000, 2'd0, 3'd0);
        queue_access(OP_WRITE16, 16'hFFFF, 16'h1234, 16'h0000, 2'd0, 3'd0);
        queue_access(OP_READ16,  16'hFFFF, 16'h0000, 16'h0000, 2'd0, 3'd0);
        queue_access(OP_READ,    16'h80FF, 16'h0000, 16'h0000, 2'd0, 3'd0);
        queue_access(OP_READ,    16'h8100, 16'h0000, 16'h0000, 2'd0, 3'd0);
        queue_access(OP_WRITE16, 16'h80FE, 16'hFFFF, 16'h0000, 2'd0, 3'd0);
        queue_access(OP_READ16,  16'h80FF, 16'h0000, 16'h0000, 2'd0, 3'd0);
        queue_access(OP_SWITCH,  16'h8000, 16'h0000, 16'h80FF, 2'd0, 3'd0);
        queue_access(OP_SPARE_LO, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3, 3'd7);
        queue_access(OP_SPARE_HI, 16'h0000, 16'h0000, 16'h0000, 2'd0, 3'd0);
        queue_random(130);
        wait_drained();

        // Extremes: full-space region capped at its first window, inverted range,
        // an overlapped read-only region and a single-byte region at the top.
        plan[0] = make_desc(16'h0000, 16'hFFFF, 4'hF, 8'hFF);
        plan[1] = make_desc(16'h9000, 16'h8000, 4'd3, 8'hAA);
        plan[2] = make_desc(16'h1000, 16'h10FF, 4'd8, 8'h00);
        plan[3] = '1;
        load_settings(plan);
        queue_random(140);
        wait_drained();

        for (int k = 0; k < 3; k++)
        begin
            for (int r = 0; r < NUM_REGIONS; r++)
            begin
                plan[r] = random_desc();
            end
            if (k == 0)
                plan[0] = '0;
            load_settings(plan);
            queue_random(143);
            wait_drained();
        end

        repeat (20) @(posedge clk);
        $write("Covered %0d read, %0d write, %0d read16, %0d write16, ",
               op_seen[OP_READ], op_seen[OP_WRITE], op_seen[OP_READ16], op_seen[OP_WRITE16]);
        $display("%0d switch, %0d load, %0d undefined requests",
                 op_seen[OP_SWITCH], op_seen[OP_LOAD],
                 op_seen[OP_SPARE_LO] + op_seen[OP_SPARE_HI]);
        $write("Checked %0d results over %0d region maps; ",
               replies_checked, settings_used);
        $display("ok/unmapped/no-region/out-of-range %0d/%0d/%0d/%0d",
                 status_seen[ST_OK], status_seen[ST_UNMAPPED],
                 status_seen[ST_NO_REGION], status_seen[ST_BANK_OOR]);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
